// ----- rtl/msm_pkg.sv -----
// Shared types and constants for the multi-stack shared memory block.
// No dependencies; every other file of the block depends on it.
`default_nettype none

package msm_pkg;

	localparam int MEM_DEPTH_DEF  = 16;
	localparam int MAX_STACKS_DEF = 8;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int CMD_W   = 2;
	localparam int STACK_W = 3;
	localparam int COUNT_W = 4;

	localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DUMP = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RSVD = 2'd3;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		logic       cfg_write;
		logic       load_item;
		logic       push_write;
		logic       pop_start;
		logic       dump_start;
		logic       step;
		logic       out_load;
		status_t    out_code;
		logic       out_mem;
		logic       out_last;
	} ctl_t;

	typedef struct packed {
		logic             range_err;
		logic [CMD_W-1:0] op;
		logic             full;
		logic             empty;
		logic             last;
		logic             out_free;
	} sts_t;

endpackage

`default_nettype wire

// ----- rtl/msm_if.sv -----
// Handshake channels of the multi-stack block: command, result, count write.
// Depends on msm_pkg for field widths.
`default_nettype none

interface msm_cmd_if #(parameter int DATA_WIDTH = msm_pkg::DATA_WIDTH_DEF);
	logic                        valid;
	logic                        ready;
	logic [msm_pkg::CMD_W-1:0]   cmd;
	logic [msm_pkg::STACK_W-1:0] stack_sel;
	logic [DATA_WIDTH-1:0]       item_data;
	modport source (output valid, output cmd, output stack_sel, output item_data, input ready);
	modport sink   (input valid, input cmd, input stack_sel, input item_data, output ready);
endinterface

interface msm_res_if #(parameter int DATA_WIDTH = msm_pkg::DATA_WIDTH_DEF);
	logic                  valid;
	logic                  ready;
	logic [1:0]            status;
	logic [DATA_WIDTH-1:0] out_data;
	logic                  last;
	modport source (output valid, output status, output out_data, output last, input ready);
	modport sink   (input valid, input status, input out_data, input last, output ready);
endinterface

interface msm_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [msm_pkg::COUNT_W-1:0] stack_count;
	modport source (output valid, output stack_count, input ready);
	modport sink   (input valid, input stack_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/msm_dp.sv -----
// Datapath: shared entry memory, per-stack fill counts, slice bases, output register.
// Depends on msm_pkg; driven by msm_ctrl through ctl_t, reports through sts_t.
`default_nettype none

module msm_dp #(
	parameter int MEM_DEPTH  = msm_pkg::MEM_DEPTH_DEF,
	parameter int MAX_STACKS = msm_pkg::MAX_STACKS_DEF,
	parameter int DATA_WIDTH = msm_pkg::DATA_WIDTH_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire msm_pkg::ctl_t           ctl,
	output msm_pkg::sts_t                sts,
	input  wire [msm_pkg::CMD_W-1:0]     cmd,
	input  wire [msm_pkg::STACK_W-1:0]   stack_sel,
	input  wire [DATA_WIDTH-1:0]         item_data,
	input  wire [msm_pkg::COUNT_W-1:0]   cfg_count,
	input  wire                          out_ready,
	output logic                         out_valid,
	output logic [1:0]                   out_status,
	output logic [DATA_WIDTH-1:0]        out_data,
	output logic                         out_last
);
	import msm_pkg::*;

	localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int PW = $clog2(MEM_DEPTH + 1);
	localparam int SW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
	localparam int MW = PW + STACK_W;

	localparam int SLICE_TAB [16] = '{
		MEM_DEPTH, MEM_DEPTH / 1, MEM_DEPTH / 2, MEM_DEPTH / 3,
		MEM_DEPTH / 4, MEM_DEPTH / 5, MEM_DEPTH / 6, MEM_DEPTH / 7,
		MEM_DEPTH / 8, MEM_DEPTH / 9, MEM_DEPTH / 10, MEM_DEPTH / 11,
		MEM_DEPTH / 12, MEM_DEPTH / 13, MEM_DEPTH / 14, MEM_DEPTH / 15
	};

	logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];
	logic [DATA_WIDTH-1:0] rd_q;

	logic [COUNT_W-1:0]    count_q;
	logic [PW-1:0]         slice_q;
	logic [PW-1:0]         fill_q [MAX_STACKS];

	logic [CMD_W-1:0]      op_q;
	logic [SW-1:0]         sidx_q;
	logic [DATA_WIDTH-1:0] word_q;
	logic                  range_q;
	logic [PW-1:0]         base_q;
	logic [PW-1:0]         limit_q;
	logic [PW-1:0]         fill_sel_q;
	logic [PW-1:0]         ptr_q;
	logic [PW-1:0]         end_q;

	logic                  out_valid_q;
	logic [1:0]            out_status_q;
	logic [DATA_WIDTH-1:0] out_data_q;
	logic                  out_last_q;

	logic [COUNT_W-1:0]    new_count;
	logic [SW-1:0]         sidx;
	logic                  range_w;
	logic                  last_stack;
	logic [MW-1:0]         base_p;
	logic [MW-1:0]         lim_p;
	logic [PW-1:0]         top_w;
	logic                  rd_en;
	logic [PW-1:0]         rd_addr;

	always_comb begin
		if (cfg_count == '0) begin
			new_count = COUNT_W'(1);
		end else if (int'(cfg_count) > MAX_STACKS) begin
			new_count = COUNT_W'(MAX_STACKS);
		end else begin
			new_count = cfg_count;
		end
	end

	assign sidx       = SW'(stack_sel);
	assign range_w    = (cmd == CMD_RSVD) || (COUNT_W'(stack_sel) >= count_q);
	assign last_stack = (COUNT_W'(stack_sel) + COUNT_W'(1)) >= count_q;
	assign base_p     = MW'(slice_q) * MW'(stack_sel);
	assign lim_p      = MW'(slice_q) * MW'(COUNT_W'(stack_sel) + COUNT_W'(1));
	assign top_w      = base_q + fill_sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_W'(1);
			slice_q <= PW'(MEM_DEPTH);
			for (int i = 0; i < MAX_STACKS; i++) fill_q[i] <= '0;
		end else if (ctl.cfg_write) begin
			count_q <= new_count;
			slice_q <= PW'(SLICE_TAB[new_count]);
			for (int i = 0; i < MAX_STACKS; i++) fill_q[i] <= '0;
		end else if (ctl.push_write) begin
			fill_q[sidx_q] <= fill_sel_q + PW'(1);
		end else if (ctl.pop_start) begin
			fill_q[sidx_q] <= fill_sel_q - PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			op_q       <= cmd;
			sidx_q     <= sidx;
			word_q     <= item_data;
			range_q    <= range_w;
			base_q     <= base_p[PW-1:0];
			limit_q    <= last_stack ? PW'(MEM_DEPTH) : lim_p[PW-1:0];
			fill_sel_q <= range_w ? '0 : fill_q[sidx];
		end
		if (ctl.pop_start) begin
			ptr_q <= top_w - PW'(1);
			end_q <= top_w;
		end else if (ctl.dump_start) begin
			ptr_q <= base_q;
			end_q <= top_w;
		end else if (ctl.step) begin
			ptr_q <= ptr_q + PW'(1);
		end
	end

	assign rd_en = ctl.pop_start || ctl.dump_start || ctl.step;

	always_comb begin
		priority if (ctl.dump_start) begin
			rd_addr = base_q;
		end else if (ctl.pop_start) begin
			rd_addr = top_w - PW'(1);
		end else begin
			rd_addr = ptr_q + PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push_write) begin
			mem[top_w[AW-1:0]] <= word_q;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_status_q <= ctl.out_code;
			out_data_q   <= ctl.out_mem ? rd_q : '0;
			out_last_q   <= ctl.out_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_data   = out_data_q;
	assign out_last   = out_last_q;

	assign sts.range_err = range_q;
	assign sts.op        = op_q;
	assign sts.full      = top_w >= limit_q;
	assign sts.empty     = fill_sel_q == '0;
	assign sts.last      = (ptr_q + PW'(1)) == end_q;
	assign sts.out_free  = !out_valid_q || out_ready;

	a_push_in_slice: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push_write |-> (top_w < limit_q))
		else $error("push outside its slice");

	a_read_in_stack: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.out_load && ctl.out_mem) |-> (ptr_q < end_q))
		else $error("word read beyond stack top");

endmodule

`default_nettype wire

// ----- rtl/msm_ctrl.sv -----
// Controller: sequences accept, evaluate and word delivery for each command.
// Depends on msm_pkg; commands msm_dp through ctl_t, reads sts_t.
`default_nettype none

module msm_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	input  wire                cfg_valid,
	output logic               in_ready,
	output logic               cfg_ready,
	input  wire msm_pkg::sts_t sts,
	output msm_pkg::ctl_t      ctl
);
	import msm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EVAL = 3'b010,
		S_SEND = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;

	always_comb begin
		ctl           = '0;
		ctl.out_code  = ST_OK;
		state_d       = state_q;
		ctl.cfg_write = cfg_valid && cfg_ready;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					ctl.load_item = 1'b1;
					state_d       = S_EVAL;
				end
			end
			S_EVAL: begin
				if (sts.out_free) begin
					priority if (sts.range_err) begin
						ctl.out_load = 1'b1;
						ctl.out_code = ST_RANGE;
						ctl.out_last = 1'b1;
						state_d      = S_IDLE;
					end else if (sts.op == CMD_PUSH) begin
						ctl.out_load   = 1'b1;
						ctl.out_last   = 1'b1;
						ctl.out_code   = sts.full ? ST_FULL : ST_OK;
						ctl.push_write = !sts.full;
						state_d        = S_IDLE;
					end else if (sts.empty) begin
						ctl.out_load = 1'b1;
						ctl.out_code = ST_EMPTY;
						ctl.out_last = 1'b1;
						state_d      = S_IDLE;
					end else if (sts.op == CMD_POP) begin
						ctl.pop_start = 1'b1;
						state_d       = S_SEND;
					end else begin
						ctl.dump_start = 1'b1;
						state_d        = S_SEND;
					end
				end
			end
			S_SEND: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					ctl.out_mem  = 1'b1;
					ctl.out_last = sts.last;
					if (sts.last) begin
						state_d = S_IDLE;
					end else begin
						ctl.step = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> sts.out_free)
		else $error("result loaded over an untaken word");

	a_cfg_excl_item: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cfg_write |-> !ctl.load_item)
		else $error("count write and command accepted together");

endmodule

`default_nettype wire

// ----- rtl/multi_stack_shared_memory_core.sv -----
// Several stacks sharing one entry memory, split into equal slices, the last stack also taking any remainder.
//
// Channels: req carries cmd (push, pop, dump), stack_sel and item_data;
// rsp returns status, out_data and last, one word per result; cfg writes
// stack_count, which rebuilds the slices and empties every stack.
// A word moves on a rising edge with valid and ready both high.
// From accept, each command passes the controller's evaluate step: push,
// rejected commands and a pop or dump of an empty stack load their result
// there; a pop or dump first reads the entry memory through its registered
// read port, and a dump then sends one entry per cycle while rsp is not
// stalled. The block takes one command at a time.
// The output register lets a new command be accepted while the previous
// result waits; a stalled receiver holds rsp and freezes delivery.
// Reset: one stack owning the whole memory, empty; entry contents are
// undefined until pushed. cfg is taken only between commands.
// Depends on msm_pkg, msm_if, msm_ctrl and msm_dp.
`default_nettype none

module multi_stack_shared_memory_core #(
	parameter int MEM_DEPTH  = msm_pkg::MEM_DEPTH_DEF,
	parameter int MAX_STACKS = msm_pkg::MAX_STACKS_DEF,
	parameter int DATA_WIDTH = msm_pkg::DATA_WIDTH_DEF
) (
	input  wire       clk,
	input  wire       arst_n,
	msm_cmd_if.sink   req,
	msm_res_if.source rsp,
	msm_cfg_if.sink   cfg
);
	import msm_pkg::*;

	ctl_t ctl;
	sts_t sts;
	logic in_ready;
	logic cfg_ready;

	assign req.ready = in_ready;
	assign cfg.ready = cfg_ready;

	msm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.cfg_valid (cfg.valid),
		.in_ready  (in_ready),
		.cfg_ready (cfg_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	msm_dp #(
		.MEM_DEPTH  (MEM_DEPTH),
		.MAX_STACKS (MAX_STACKS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.cmd        (req.cmd),
		.stack_sel  (req.stack_sel),
		.item_data  (req.item_data),
		.cfg_count  (cfg.stack_count),
		.out_ready  (rsp.ready),
		.out_valid  (rsp.valid),
		.out_status (rsp.status),
		.out_data   (rsp.out_data),
		.out_last   (rsp.last)
	);

endmodule

`default_nettype wire
